/* design/rhc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared types, constants and arithmetic helpers for the RGB/HSL converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

    localparam int FRAC_BITS    = 15;
    localparam int CHANNEL_BITS = 8;
    localparam int HSL_W        = 16;
    localparam int DIV_W        = 11;
    localparam int QUO_W        = 16;
    localparam int DIV_STAGES   = 4;
    localparam int DIV_STEP     = QUO_W / DIV_STAGES;
    localparam int DEPTH        = 6;

    localparam logic [HSL_W-1:0] ONE_Q = HSL_W'(1 << FRAC_BITS);

    typedef enum logic
    {
        DIR_RGB2HSL = 1'b0,
        DIR_HSL2RGB = 1'b1
    } dir_t;

    typedef struct packed
    {
        logic [CHANNEL_BITS-1:0] red_in;
        logic [CHANNEL_BITS-1:0] green_in;
        logic [CHANNEL_BITS-1:0] blue_in;
        logic [HSL_W-1:0]        hue_in;
        logic [HSL_W-1:0]        sat_in;
        logic [HSL_W-1:0]        light_in;
    } pix_in_t;

    typedef struct packed
    {
        logic [CHANNEL_BITS-1:0] red_out;
        logic [CHANNEL_BITS-1:0] green_out;
        logic [CHANNEL_BITS-1:0] blue_out;
        logic [HSL_W-1:0]        hue_out;
        logic [HSL_W-1:0]        sat_out;
        logic [HSL_W-1:0]        light_out;
    } pix_out_t;

    // one restoring step: returns {quotient bit, new remainder}
    function automatic logic [DIV_W:0] div_step(input logic [DIV_W-1:0] rem,
                                                input logic [DIV_W-1:0] dvs);
        logic [DIV_W:0] t;
        logic [DIV_W:0] d;
        t = {rem, 1'b0};
        d = {1'b0, dvs};
        if (t >= d)
        begin
            div_step = {1'b1, DIV_W'(t - d)};
        end
        else
        begin
            div_step = {1'b0, t[DIV_W-1:0]};
        end
    endfunction

    // floor(255 * (y * 2^15 + tl) / 2^45), masked to a byte
    function automatic logic [CHANNEL_BITS-1:0] to_channel(input logic [31:0] y,
                                                           input logic [FRAC_BITS-1:0] tl);
        logic [39:0] u;
        logic [22:0] lo;
        lo = ({8'd0, tl} << 8) - {8'd0, tl};
        u  = ({8'd0, y} << 8) - {8'd0, y} + 40'(lo >> FRAC_BITS);
        to_channel = u[2*FRAC_BITS+CHANNEL_BITS-1:2*FRAC_BITS];
    endfunction

endpackage

/* design/rhc_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_div
// Pipelined restoring divider: q = floor(a * 2^15 / b) for a <= b, four bits
// of quotient per stage over four stages.
// ----------------------------------------------------------------------------
module rhc_div
(
    input  logic                      clk,
    input  logic                      en,
    input  logic [rhc_pkg::DIV_W-1:0] a,
    input  logic [rhc_pkg::DIV_W-1:0] b,
    output logic [rhc_pkg::QUO_W-1:0] q
);
    import rhc_pkg::*;

    logic [DIV_W-1:0] rem_reg [DIV_STAGES];
    logic [QUO_W-1:0] quo_reg [DIV_STAGES];
    logic [DIV_W-1:0] dvs_reg [DIV_STAGES];
    logic [DIV_W-1:0] rem_next [DIV_STAGES];
    logic [QUO_W-1:0] quo_next [DIV_STAGES];
    logic [DIV_W-1:0] dvs_next [DIV_STAGES];

    always_comb
    begin
        logic [DIV_W-1:0] r;
        logic [QUO_W-1:0] qq;
        logic [DIV_W:0]   st;
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (k == 0)
            begin
                // leading integer bit
                if (a >= b)
                begin
                    r  = a - b;
                    qq = QUO_W'(1);
                end
                else
                begin
                    r  = a;
                    qq = '0;
                end
                dvs_next[k] = b;
                for (int j = 1; j < DIV_STEP; j++)
                begin
                    st = div_step(r, b);
                    r  = st[DIV_W-1:0];
                    qq = {qq[QUO_W-2:0], st[DIV_W]};
                end
            end
            else
            begin
                r  = rem_reg[k-1];
                qq = quo_reg[k-1];
                dvs_next[k] = dvs_reg[k-1];
                for (int j = 0; j < DIV_STEP; j++)
                begin
                    st = div_step(r, dvs_reg[k-1]);
                    r  = st[DIV_W-1:0];
                    qq = {qq[QUO_W-2:0], st[DIV_W]};
                end
            end
            rem_next[k] = r;
            quo_next[k] = qq;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
                dvs_reg[k] <= dvs_next[k];
            end
        end
    end

    assign q = quo_reg[DIV_STAGES-1];

endmodule

/* design/rhc_rgb2hsl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_rgb2hsl
// RGB to HSL path: min/max and operand setup, then two pipelined dividers
// for saturation and hue. Results valid five stages after the input.
// ----------------------------------------------------------------------------
module rhc_rgb2hsl
(
    input  logic                            clk,
    input  logic                            en,
    input  logic [rhc_pkg::CHANNEL_BITS-1:0] red,
    input  logic [rhc_pkg::CHANNEL_BITS-1:0] green,
    input  logic [rhc_pkg::CHANNEL_BITS-1:0] blue,
    output logic [rhc_pkg::HSL_W-1:0]        hue,
    output logic [rhc_pkg::HSL_W-1:0]        sat,
    output logic [rhc_pkg::HSL_W-1:0]        light
);
    import rhc_pkg::*;

    logic [7:0]       mx;
    logic [7:0]       mn;
    logic [7:0]       d;
    logic [8:0]       sum;
    logic [14:0]      y64;
    logic [15:0]      t255;
    logic [8:0]       den;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] d6;

    logic [DIV_W-1:0] sat_a_reg;
    logic [DIV_W-1:0] sat_b_reg;
    logic [DIV_W-1:0] hue_a_reg;
    logic [DIV_W-1:0] hue_b_reg;
    logic [HSL_W-1:0] light_reg [DIV_STAGES+1];
    logic             zero_reg  [DIV_STAGES+1];
    logic [QUO_W-1:0] sat_q;
    logic [QUO_W-1:0] hue_q;

    always_comb
    begin
        mx = red;
        mn = red;
        if (green > mx)
        begin
            mx = green;
        end
        if (blue > mx)
        begin
            mx = blue;
        end
        if (green < mn)
        begin
            mn = green;
        end
        if (blue < mn)
        begin
            mn = blue;
        end
        d    = mx - mn;
        sum  = {1'b0, mx} + {1'b0, mn};
        // sum * 2^14 / 255 = 64 * sum + floor(64 * sum / 255)
        y64  = {sum, 6'd0};
        t255 = {1'b0, y64} + 16'd1 + 16'(y64 >> 8);
        den  = (sum < 9'd255) ? sum : (9'd510 - sum);
        d6   = DIV_W'({3'd0, d} * 11'd6);
        if (red == mx)
        begin
            if (green >= blue)
            begin
                num = DIV_W'(green - blue);
            end
            else
            begin
                num = d6 - DIV_W'(blue - green);
            end
        end
        else if (green == mx)
        begin
            num = DIV_W'({d, 1'b0}) + DIV_W'(blue) - DIV_W'(red);
        end
        else
        begin
            num = DIV_W'({d, 2'b00}) + DIV_W'(red) - DIV_W'(green);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_a_reg    <= DIV_W'(d);
            sat_b_reg    <= DIV_W'(den);
            hue_a_reg    <= num;
            hue_b_reg    <= d6;
            light_reg[0] <= {1'b0, y64} + {8'd0, t255[15:8]};
            zero_reg[0]  <= (d == 8'd0);
            for (int k = 1; k <= DIV_STAGES; k++)
            begin
                light_reg[k] <= light_reg[k-1];
                zero_reg[k]  <= zero_reg[k-1];
            end
        end
    end

    rhc_div u_sat_div
    (
        .clk (clk),
        .en  (en),
        .a   (sat_a_reg),
        .b   (sat_b_reg),
        .q   (sat_q)
    );

    rhc_div u_hue_div
    (
        .clk (clk),
        .en  (en),
        .a   (hue_a_reg),
        .b   (hue_b_reg),
        .q   (hue_q)
    );

    assign hue   = zero_reg[DIV_STAGES] ? '0 : hue_q;
    assign sat   = zero_reg[DIV_STAGES] ? '0 : sat_q;
    assign light = light_reg[DIV_STAGES];

endmodule

/* design/rhc_hsl2rgb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_hsl2rgb
// HSL to RGB path: clamp, chroma product, ramp product, channel levels,
// byte scaling, then sextant select. Results valid five stages after input.
// ----------------------------------------------------------------------------
module rhc_hsl2rgb
(
    input  logic                             clk,
    input  logic                             en,
    input  logic [rhc_pkg::HSL_W-1:0]        hue,
    input  logic [rhc_pkg::HSL_W-1:0]        sat,
    input  logic [rhc_pkg::HSL_W-1:0]        light,
    output logic [rhc_pkg::CHANNEL_BITS-1:0] red,
    output logic [rhc_pkg::CHANNEL_BITS-1:0] green,
    output logic [rhc_pkg::CHANNEL_BITS-1:0] blue
);
    import rhc_pkg::*;

    logic [HSL_W-1:0]     h_c;
    logic [HSL_W-1:0]     s_c;
    logic [HSL_W-1:0]     l_c;
    logic [17:0]          x6;

    // stage 1
    logic [HSL_W-1:0]     s1_l_reg;
    logic [HSL_W-1:0]     s1_s_reg;
    logic [HSL_W-1:0]     s1_m_reg;
    logic [2:0]           s1_sext_reg;
    logic [FRAC_BITS-1:0] s1_fr_reg;
    // stage 2
    logic [30:0]          s2_p_reg;
    logic [HSL_W-1:0]     s2_l_reg;
    logic [2:0]           s2_sext_reg;
    logic [FRAC_BITS-1:0] s2_fr_reg;
    // stage 3
    logic [45:0]          s3_t_reg;
    logic [31:0]          s3_vn_reg;
    logic [31:0]          s3_mn_reg;
    logic [2:0]           s3_sext_reg;
    logic                 s3_gray_reg;
    logic [7:0]           s3_grayv_reg;
    // stage 4
    logic [31:0]          s4_yv_reg;
    logic [31:0]          s4_ym_reg;
    logic [31:0]          s4_y1_reg;
    logic [FRAC_BITS-1:0] s4_tl1_reg;
    logic [31:0]          s4_y2_reg;
    logic [FRAC_BITS-1:0] s4_tl2_reg;
    logic [2:0]           s4_sext_reg;
    logic                 s4_gray_reg;
    logic [7:0]           s4_grayv_reg;
    // stage 5
    logic [7:0]           s5_vv_reg;
    logic [7:0]           s5_mm_reg;
    logic [7:0]           s5_m1_reg;
    logic [7:0]           s5_m2_reg;
    logic [2:0]           s5_sext_reg;
    logic                 s5_gray_reg;
    logic [7:0]           s5_grayv_reg;

    logic [31:0]          th;
    logic [FRAC_BITS-1:0] tl;
    logic [31:0]          vmt;
    logic [23:0]          g255;

    always_comb
    begin
        h_c = (hue > ONE_Q) ? ONE_Q : hue;
        s_c = (sat > ONE_Q) ? ONE_Q : sat;
        l_c = (light > ONE_Q) ? ONE_Q : light;
        x6  = 18'({2'd0, h_c} * 18'd6);
    end

    always_comb
    begin
        th   = s3_t_reg[45:14];
        tl   = {s3_t_reg[13:0], 1'b0};
        vmt  = s3_vn_reg - th;
        g255 = ({8'd0, s2_l_reg} << 8) - {8'd0, s2_l_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // clamp and multiplicand select
            s1_l_reg    <= l_c;
            s1_s_reg    <= s_c;
            s1_m_reg    <= ({l_c, 1'b0} <= {1'b0, ONE_Q}) ? l_c : (ONE_Q - l_c);
            s1_sext_reg <= x6[17:15];
            s1_fr_reg   <= x6[14:0];

            // chroma term p
            s2_p_reg    <= {15'd0, s1_s_reg} * {15'd0, s1_m_reg};
            s2_l_reg    <= s1_l_reg;
            s2_sext_reg <= s1_sext_reg;
            s2_fr_reg   <= s1_fr_reg;

            // ramp product and v, m
            s3_t_reg     <= {15'd0, s2_p_reg} * {31'd0, s2_fr_reg};
            s3_vn_reg    <= {1'b0, s2_l_reg, 15'd0} + {1'b0, s2_p_reg};
            s3_mn_reg    <= {1'b0, s2_l_reg, 15'd0} - {1'b0, s2_p_reg};
            s3_sext_reg  <= s2_sext_reg;
            s3_gray_reg  <= (s2_l_reg == '0) || (s2_sext_reg > 3'd5);
            s3_grayv_reg <= g255[22:15];

            // channel levels
            s4_yv_reg    <= s3_vn_reg;
            s4_ym_reg    <= s3_mn_reg;
            s4_y1_reg    <= s3_mn_reg + th;
            s4_tl1_reg   <= tl;
            s4_y2_reg    <= (tl == '0) ? vmt : (vmt - 32'd1);
            s4_tl2_reg   <= (tl == '0) ? '0 : FRAC_BITS'(ONE_Q - {1'b0, tl});
            s4_sext_reg  <= s3_sext_reg;
            s4_gray_reg  <= s3_gray_reg;
            s4_grayv_reg <= s3_grayv_reg;

            // byte scaling
            s5_vv_reg    <= to_channel(s4_yv_reg, '0);
            s5_mm_reg    <= to_channel(s4_ym_reg, '0);
            s5_m1_reg    <= to_channel(s4_y1_reg, s4_tl1_reg);
            s5_m2_reg    <= to_channel(s4_y2_reg, s4_tl2_reg);
            s5_sext_reg  <= s4_sext_reg;
            s5_gray_reg  <= s4_gray_reg;
            s5_grayv_reg <= s4_grayv_reg;
        end
    end

    always_comb
    begin
        if (s5_gray_reg)
        begin
            red   = s5_grayv_reg;
            green = s5_grayv_reg;
            blue  = s5_grayv_reg;
        end
        else
        begin
            case (s5_sext_reg)
                3'd0:
                begin
                    red = s5_vv_reg; green = s5_m1_reg; blue = s5_mm_reg;
                end
                3'd1:
                begin
                    red = s5_m2_reg; green = s5_vv_reg; blue = s5_mm_reg;
                end
                3'd2:
                begin
                    red = s5_mm_reg; green = s5_vv_reg; blue = s5_m1_reg;
                end
                3'd3:
                begin
                    red = s5_mm_reg; green = s5_m2_reg; blue = s5_vv_reg;
                end
                3'd4:
                begin
                    red = s5_m1_reg; green = s5_mm_reg; blue = s5_vv_reg;
                end
                default:
                begin
                    red = s5_vv_reg; green = s5_mm_reg; blue = s5_m2_reg;
                end
            endcase
        end
    end

endmodule

/* design/rgb_hsl_color_convert.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_hsl_color_convert
// Per-pixel RGB <-> HSL converter, direction chosen by a config register.
//
// channel  signals                    role
// cfg      cfg_valid/cfg_ready/cfg_data   direction write, always ready
// src      src_valid/src_stall/src_data   pixel in, transfer when !src_stall
// dst      dst_valid/dst_stall/dst_data   pixel out, transfer when !dst_stall
//
// six register stages, one pixel per cycle while the output is not stalled
// depth set by the 16-bit quotient of the saturation/hue dividers (4 bits/stage)
// reset clears the direction and all stage valid bits
// a stalled result freezes the whole pipeline; src_stall follows it
// ----------------------------------------------------------------------------
module rgb_hsl_color_convert
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data,
    input  logic              src_valid,
    output logic              src_stall,
    input  rhc_pkg::pix_in_t  src_data,
    output logic              dst_valid,
    input  logic              dst_stall,
    output rhc_pkg::pix_out_t dst_data
);
    import rhc_pkg::*;

    dir_t             direction_reg;
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    dir_t             dir_reg [DEPTH];
    pix_out_t         out_reg;
    pix_out_t         out_next;
    logic             en;

    logic [HSL_W-1:0]        hue_r;
    logic [HSL_W-1:0]        sat_r;
    logic [HSL_W-1:0]        light_r;
    logic [CHANNEL_BITS-1:0] red_r;
    logic [CHANNEL_BITS-1:0] green_r;
    logic [CHANNEL_BITS-1:0] blue_r;

    assign cfg_ready = 1'b1;
    assign en        = !(valid_reg[DEPTH-1] && dst_stall);
    assign src_stall = !en;
    assign dst_valid = valid_reg[DEPTH-1];
    assign dst_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= DIR_RGB2HSL;
        end
        else if (cfg_valid && cfg_ready)
        begin
            direction_reg <= dir_t'(cfg_data);
        end
    end

    assign valid_next = {valid_reg[DEPTH-2:0], src_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    rhc_rgb2hsl u_rgb2hsl
    (
        .clk   (clk),
        .en    (en),
        .red   (src_data.red_in),
        .green (src_data.green_in),
        .blue  (src_data.blue_in),
        .hue   (hue_r),
        .sat   (sat_r),
        .light (light_r)
    );

    rhc_hsl2rgb u_hsl2rgb
    (
        .clk   (clk),
        .en    (en),
        .hue   (src_data.hue_in),
        .sat   (src_data.sat_in),
        .light (src_data.light_in),
        .red   (red_r),
        .green (green_r),
        .blue  (blue_r)
    );

    always_comb
    begin
        out_next = '0;
        if (dir_reg[DEPTH-2] == DIR_HSL2RGB)
        begin
            out_next.red_out   = red_r;
            out_next.green_out = green_r;
            out_next.blue_out  = blue_r;
        end
        else
        begin
            out_next.hue_out   = hue_r;
            out_next.sat_out   = sat_r;
            out_next.light_out = light_r;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dir_reg[0] <= direction_reg;
            for (int k = 1; k < DEPTH; k++)
            begin
                dir_reg[k] <= dir_reg[k-1];
            end
            out_reg <= out_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dir_reg[DEPTH-1] == DIR_RGB2HSL |->
            dst_data.red_out == '0 && dst_data.green_out == '0 && dst_data.blue_out == '0)
        else $error("rgb fields set on an hsl result");

    assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dir_reg[DEPTH-1] == DIR_HSL2RGB |->
            dst_data.hue_out == '0 && dst_data.sat_out == '0 && dst_data.light_out == '0)
        else $error("hsl fields set on an rgb result");

    assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid |-> dst_data.hue_out < ONE_Q && dst_data.sat_out <= ONE_Q &&
            dst_data.light_out <= ONE_Q)
        else $error("hsl result out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        src_stall |-> dst_valid && dst_stall)
        else $error("input stalled with free output");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb/hsl converter testbench
// Drives pixels through both conversion directions under several idle and
// stall mixes, predicts every result with an exact integer model and checks
// each output transfer against its whole predicted pixel, in order.
// ----------------------------------------------------------------------------
module testbench;
    import rhc_pkg::*;

    localparam int ONE_I = 1 << FRAC_BITS;
    localparam int WATCHDOG = 20000;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_data;
    logic src_valid;
    logic src_stall;
    pix_in_t src_data;
    logic dst_valid;
    logic dst_stall;
    pix_out_t dst_data;

    dir_t cur_dir;
    pix_out_t expected_pix[$];
    int mismatches;
    int checked;
    int idle_cycles;
    int src_idle_pct;
    int dst_stall_pct;

    rgb_hsl_color_convert u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic [7:0] byte_of(input longint unsigned y, input longint unsigned tl);
        longint unsigned u;
        u = 255 * y + ((255 * tl) >> FRAC_BITS);
        return 8'((u >> (2 * FRAC_BITS)) & 255);
    endfunction

    function automatic pix_out_t predict_pixel(input dir_t dir, input pix_in_t px);
        pix_out_t o;
        longint unsigned r, g, b, mx, mn, d, sum, den, num;
        longint unsigned h, s, l, p, vn, mnv, sext, fr, ph, pl, lowp, th, tl;
        logic [7:0] vv, mm, mid1, mid2, gray;
        o = '0;
        if (dir == DIR_RGB2HSL)
        begin
            r = px.red_in;
            g = px.green_in;
            b = px.blue_in;
            mx = r;
            mn = r;
            if (g > mx) mx = g;
            if (b > mx) mx = b;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            d = mx - mn;
            sum = mx + mn;
            o.light_out = 16'((sum * ONE_I) / 510);
            if (d != 0)
            begin
                den = (sum < 255) ? sum : (510 - sum);
                o.sat_out = 16'((d * ONE_I) / den);
                if (r == mx)
                    num = (g >= b) ? (g - b) : (6 * d - (b - g));
                else if (g == mx)
                    num = 2 * d + b - r;
                else
                    num = 4 * d + r - g;
                o.hue_out = 16'((num * ONE_I) / (6 * d));
            end
        end
        else
        begin
            h = (px.hue_in > ONE_I) ? ONE_I : px.hue_in;
            s = (px.sat_in > ONE_I) ? ONE_I : px.sat_in;
            l = (px.light_in > ONE_I) ? ONE_I : px.light_in;
            p = (2 * l <= ONE_I) ? (l * s) : (s * (ONE_I - l));
            vn = l * ONE_I + p;
            mnv = l * ONE_I - p;
            sext = (6 * h) >> FRAC_BITS;
            fr = (6 * h) & (ONE_I - 1);
            if (vn == 0 || sext > 5)
            begin
                gray = byte_of(l * ONE_I, 0);
                o.red_out = gray;
                o.green_out = gray;
                o.blue_out = gray;
            end
            else
            begin
                ph = p >> FRAC_BITS;
                pl = p & (ONE_I - 1);
                lowp = 2 * pl * fr;
                th = 2 * ph * fr + (lowp >> FRAC_BITS);
                tl = lowp & (ONE_I - 1);
                vv = byte_of(vn, 0);
                mm = byte_of(mnv, 0);
                mid1 = byte_of(mnv + th, tl);
                mid2 = (tl == 0) ? byte_of(vn - th, 0) : byte_of(vn - th - 1, ONE_I - tl);
                case (sext)
                    0: {o.red_out, o.green_out, o.blue_out} = {vv, mid1, mm};
                    1: {o.red_out, o.green_out, o.blue_out} = {mid2, vv, mm};
                    2: {o.red_out, o.green_out, o.blue_out} = {mm, vv, mid1};
                    3: {o.red_out, o.green_out, o.blue_out} = {mm, mid2, vv};
                    4: {o.red_out, o.green_out, o.blue_out} = {mid1, mm, vv};
                    default: {o.red_out, o.green_out, o.blue_out} = {vv, mm, mid2};
                endcase
            end
        end
        return o;
    endfunction

    // receiver stall and result checking
    always @(posedge clk)
    begin
        pix_out_t exp_pix;
        if (rst_n && dst_valid && !dst_stall)
        begin
            if (expected_pix.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", dst_data);
            end
            else
            begin
                exp_pix = expected_pix.pop_front();
                checked++;
                if (dst_data !== exp_pix)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp r%0d g%0d b%0d h%0d s%0d l%0d, got r%0d g%0d b%0d h%0d s%0d l%0d",
                            exp_pix.red_out, exp_pix.green_out, exp_pix.blue_out,
                            exp_pix.hue_out, exp_pix.sat_out, exp_pix.light_out,
                            dst_data.red_out, dst_data.green_out, dst_data.blue_out,
                            dst_data.hue_out, dst_data.sat_out, dst_data.light_out);
                end
            end
        end
        dst_stall <= ($urandom_range(99) < dst_stall_pct);
    end

    // watchdog on cycles with no transfer
    always @(posedge clk)
    begin
        if ((src_valid && !src_stall) || (dst_valid && !dst_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("** rgb_hsl_color_convert: FAILED **");
            $finish;
        end
    end

    task automatic send_pixel(input pix_in_t px);
        while ($urandom_range(99) < src_idle_pct)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_data <= px;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        expected_pix.push_back(predict_pixel(cur_dir, px));
    endtask

    task automatic drain();
        src_valid <= 1'b0;
        while (expected_pix.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_direction(input dir_t dir);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= dir;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_dir = dir;
    endtask

    function automatic pix_in_t rand_pixel();
        pix_in_t px;
        px = pix_in_t'({$urandom, $urandom, $urandom});
        return px;
    endfunction

    function automatic logic [15:0] rand_hsl();
        case ($urandom_range(9))
            0: return 16'($urandom);
            1: return 16'(ONE_I);
            2: return 16'd0;
            default: return 16'($urandom_range(ONE_I));
        endcase
    endfunction

    task automatic test_rgb_directed();
        pix_in_t px;
        logic [7:0] vals[6] = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd127, 8'd254};
        set_direction(DIR_RGB2HSL);
        for (int i = 0; i < 18; i++)
        begin
            px = rand_pixel();
            px.red_in = vals[i % 6];
            px.green_in = vals[(i / 6 + i) % 6];
            px.blue_in = vals[(i / 3) % 6];
            send_pixel(px);
        end
    endtask

    task automatic test_hsl_directed();
        pix_in_t px;
        logic [15:0] hv[8] = '{16'd0, 16'd32768, 16'd5461, 16'd5462, 16'd16384,
                               16'd27307, 16'hffff, 16'd10923};
        set_direction(DIR_HSL2RGB);
        for (int i = 0; i < 16; i++)
        begin
            px = rand_pixel();
            px.hue_in = hv[i % 8];
            px.sat_in = (i % 3 == 0) ? 16'd32768 : (i % 3 == 1) ? 16'd0 : 16'hffff;
            px.light_in = (i % 4 == 0) ? 16'd0 : (i % 4 == 1) ? 16'd16384 :
                          (i % 4 == 2) ? 16'd32768 : 16'd40000;
            send_pixel(px);
        end
    endtask

    task automatic test_random_phase(input int src_pct, input int dst_pct);
        pix_in_t px;
        src_idle_pct = src_pct;
        dst_stall_pct = dst_pct;
        for (int k = 0; k < 4; k++)
        begin
            set_direction(dir_t'(k % 2));
            for (int i = 0; i < 120; i++)
            begin
                px = rand_pixel();
                if (cur_dir == DIR_HSL2RGB && $urandom_range(3) != 0)
                begin
                    px.hue_in = rand_hsl();
                    px.sat_in = rand_hsl();
                    px.light_in = rand_hsl();
                end
                send_pixel(px);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        src_valid = 1'b0;
        src_data = '0;
        dst_stall = 1'b0;
        cur_dir = DIR_RGB2HSL;
        mismatches = 0;
        checked = 0;
        idle_cycles = 0;
        src_idle_pct = 0;
        dst_stall_pct = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_rgb_directed();
        test_hsl_directed();
        test_random_phase(0, 0);
        test_random_phase(67, 0);
        test_random_phase(0, 67);
        test_random_phase(32, 32);
        drain();
        $display("checked %0d results over both directions, directed edges and four idle/stall mixes",
                 checked);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0 && expected_pix.size() == 0)
            $display("** rgb_hsl_color_convert: PASSED **");
        else
            $display("** rgb_hsl_color_convert: FAILED **");
        $finish;
    end
endmodule

/* sim.f */
design/rhc_pkg.sv
design/rhc_div.sv
design/rhc_rgb2hsl.sv
design/rhc_hsl2rgb.sv
design/rgb_hsl_color_convert.sv
dv/testbench.sv
